// ===== rtl/sm4cm_pkg.sv =====
// Shared constants, tables and round functions for the SM4 chaining-mode core.
package sm4cm_pkg;

   localparam int RK_DEPTH = 32;
   localparam int RK_AW    = $clog2(RK_DEPTH);
   localparam int WORD_W   = 32;
   localparam int BLK_W    = 128;
   localparam int HALF_W   = 64;
   localparam int CSR_AW   = 6;
   localparam int CSR_DW   = 64;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [BLK_W-1:0]  block_type;
   typedef logic [RK_AW-1:0]  rk_addr_type;

   // Chaining modes
   localparam logic [1:0] MODE_ECB = 2'd0;
   localparam logic [1:0] MODE_CBC = 2'd1;
   localparam logic [1:0] MODE_CFB = 2'd2;
   localparam logic [1:0] MODE_OFB = 2'd3;

   // Register indexes (byte address is 8 * index)
   localparam logic [2:0] REG_KEY_HIGH = 3'd0;
   localparam logic [2:0] REG_KEY_LOW  = 3'd1;
   localparam logic [2:0] REG_IV_HIGH  = 3'd2;
   localparam logic [2:0] REG_IV_LOW   = 3'd3;
   localparam logic [2:0] REG_MODE     = 3'd4;
   localparam logic [2:0] REG_DIR      = 3'd5;

   localparam word_type FK0 = 32'ha3b1bac6;
   localparam word_type FK1 = 32'h56aa3350;
   localparam word_type FK2 = 32'h677d9197;
   localparam word_type FK3 = 32'hb27022dc;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Byte-wise S-box substitution
   function automatic word_type tau(input word_type x);
      tau = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   function automatic word_type rol(input word_type x, input int unsigned n);
      rol = (x << n) | (x >> (WORD_W - n));
   endfunction

   // Linear layer of the data rounds
   function automatic word_type lin_round(input word_type t);
      lin_round = t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
   endfunction

   // Linear layer of the key schedule
   function automatic word_type lin_key(input word_type t);
      lin_key = t ^ rol(t, 13) ^ rol(t, 23);
   endfunction

   // CK constant: byte j of word i is (4i + j) * 7 mod 256
   function automatic word_type ck_word(input rk_addr_type i);
      logic [7:0] idx;
      word_type   w;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         idx = {1'b0, i, 2'(j)};
         w   = {w[23:0], 8'((idx << 3) - idx)};
      end
      ck_word = w;
   endfunction

   // Block fed into the cipher for each mode
   function automatic block_type cipher_src(input logic [1:0] mode, input logic dec,
                                            input block_type data, input block_type cv);
      case (mode)
         MODE_ECB: cipher_src = data;
         MODE_CBC: cipher_src = dec ? data : (data ^ cv);
         MODE_CFB: cipher_src = cv;
         MODE_OFB: cipher_src = cv;
         default:  cipher_src = data;
      endcase
   endfunction

endpackage

// ===== rtl/sm4cm_rk_ram.sv =====
// Round key store: 32 x 32 synchronous RAM, one write and one registered read port.
module sm4cm_rk_ram
   import sm4cm_pkg::*;
(
   input  logic        clock,
   input  logic        wr_en,
   input  rk_addr_type wr_addr,
   input  word_type    wr_data,
   input  rk_addr_type rd_addr,
   output word_type    rd_data
);

   word_type mem [RK_DEPTH];
   word_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sm4_cipher_with_chaining_modes_core.sv =====
// SM4 block cipher core with ECB, CBC, CFB and OFB chaining and an APB-style register port.
//
// One 128-bit request in, one 128-bit result out. A single shared round unit runs one SM4
// round per cycle and reads its round key from a 32-entry RAM with a registered read port.
// A new request is accepted only after the previous block has finished its rounds, in the
// same cycle the previous result is written, but not while a stalled result holds it.
// The first request after reset or after any register write first expands the 32 round keys
// into the RAM (one key per cycle), primes the key read in a prime state, and loads
// the chaining value from the IV registers. Registers lie at byte address 8 * index and are
// 64 bits wide; write them only while the core is idle. The result register decouples the
// output: a new request is taken while a result waits.
module sm4_cipher_with_chaining_modes_core
   import sm4cm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [HALF_W-1:0]   req_data_high,
   input  logic [HALF_W-1:0]   req_data_low,
   input  logic                req_last_block,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HALF_W-1:0]   rsp_result_high,
   output logic [HALF_W-1:0]   rsp_result_low,
   output logic                rsp_last_out,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_KEY   = 3'd1;
   localparam logic [2:0] ST_PRIME = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam rk_addr_type RK_LAST = rk_addr_type'(RK_DEPTH - 1);

   // configuration registers
   logic [HALF_W-1:0] key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic [1:0]        mode_ff;
   logic              dir_ff;

   // control
   logic [2:0]  state_ff, state_in;
   rk_addr_type cnt_ff, cnt_in;
   logic        keys_ready_ff, keys_ready_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // datapath
   block_type         words_ff, words_in;
   block_type         cv_ff, cv_in;
   block_type         data_ff, data_in;
   logic              last_ff, last_in;
   logic [HALF_W-1:0] rsp_high_ff, rsp_high_in, rsp_low_ff, rsp_low_in;
   logic              rsp_last_ff, rsp_last_in;
   word_type          rk_ram_rd_data;

   logic        cfg_wr;
   logic [2:0]  cfg_idx;
   logic        rev;
   logic        out_free;
   logic        take;
   logic        accept;
   word_type    rk;
   word_type    mix;
   word_type    sub;
   word_type    new_word;
   rk_addr_type rd_addr;
   rk_addr_type nxt_round;
   block_type   e_blk;
   block_type   result;
   block_type   cv_next;
   block_type   cv_cur;
   block_type   src;

   // register port
   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[CSR_AW-1:3];
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
         mode_ff     <= MODE_ECB;
         dir_ff      <= 1'b0;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            REG_KEY_LOW:  key_low_ff  <= csr_pwdata;
            REG_IV_HIGH:  iv_high_ff  <= csr_pwdata;
            REG_IV_LOW:   iv_low_ff   <= csr_pwdata;
            REG_MODE:     mode_ff     <= csr_pwdata[1:0];
            REG_DIR:      dir_ff      <= csr_pwdata[0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_IV_HIGH:  csr_prdata = iv_high_ff;
         REG_IV_LOW:   csr_prdata = iv_low_ff;
         REG_MODE:     csr_prdata = {{(CSR_DW-2){1'b0}}, mode_ff};
         REG_DIR:      csr_prdata = {{(CSR_DW-1){1'b0}}, dir_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // reversed key order only for ECB/CBC decryption
   assign rev = dir_ff & ((mode_ff == MODE_ECB) | (mode_ff == MODE_CBC));

   // shared round unit: key schedule or data round
   assign rk       = rk_ram_rd_data;
   assign mix      = words_ff[95:64] ^ words_ff[63:32] ^ words_ff[31:0] ^
                     ((state_ff == ST_KEY) ? ck_word(cnt_ff) : rk);
   assign sub      = tau(mix);
   assign new_word = words_ff[127:96] ^
                     ((state_ff == ST_KEY) ? lin_key(sub) : lin_round(sub));

   // cipher output is the final words in reversed order
   assign e_blk = {words_ff[31:0], words_ff[63:32], words_ff[95:64], words_ff[127:96]};

   // chaining post-processing
   always_comb begin
      case (mode_ff)
         MODE_ECB: begin
            result  = e_blk;
            cv_next = cv_ff;
         end
         MODE_CBC: begin
            result  = dir_ff ? (e_blk ^ cv_ff) : e_blk;
            cv_next = dir_ff ? data_ff : e_blk;
         end
         MODE_CFB: begin
            result  = e_blk ^ data_ff;
            cv_next = dir_ff ? data_ff : (e_blk ^ data_ff);
         end
         MODE_OFB: begin
            result  = e_blk ^ data_ff;
            cv_next = e_blk;
         end
         default: begin
            result  = e_blk;
            cv_next = cv_ff;
         end
      endcase
   end

   // handshakes
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign take      = (state_ff == ST_IDLE) | ((state_ff == ST_DONE) & out_free);
   assign req_stall = ~take;
   assign accept    = req_valid & take;

   // chaining value forwarded when a request enters as the previous one retires
   assign cv_cur = (state_ff == ST_DONE) ? cv_next : cv_ff;
   assign src    = (state_ff == ST_PRIME) ? cipher_src(mode_ff, dir_ff, data_ff, cv_ff)
                                          : cipher_src(mode_ff, dir_ff,
                                                       {req_data_high, req_data_low}, cv_cur);

   // key read address: first round key, or the one after the current round
   assign nxt_round = cnt_ff + 1'b1;
   always_comb begin
      if (state_ff == ST_ROUND) begin
         rd_addr = rev ? ~nxt_round : nxt_round;
      end else begin
         rd_addr = rev ? RK_LAST : '0;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      keys_ready_in = keys_ready_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      words_in      = words_ff;
      cv_in         = cv_ff;
      data_in       = data_ff;
      last_in       = last_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_last_in   = rsp_last_ff;

      // retire finished block into the result register
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_high_in  = result[127:64];
         rsp_low_in   = result[63:0];
         rsp_last_in  = last_ff;
         cv_in        = cv_next;
         state_in     = ST_IDLE;
      end

      case (state_ff)
         ST_KEY: begin
            words_in = {words_ff[95:0], new_word};
            cnt_in   = nxt_round;
            if (cnt_ff == RK_LAST) begin
               keys_ready_in = 1'b1;
               state_in      = ST_PRIME;
            end
         end
         ST_PRIME: begin
            words_in = src;
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            words_in = {words_ff[95:0], new_word};
            cnt_in   = nxt_round;
            if (cnt_ff == RK_LAST) begin
               state_in = ST_DONE;
            end
         end
         default: ;
      endcase

      // new request
      if (accept) begin
         data_in = {req_data_high, req_data_low};
         last_in = req_last_block;
         cnt_in  = '0;
         if (!keys_ready_ff) begin
            words_in = {key_high_ff[63:32] ^ FK0, key_high_ff[31:0] ^ FK1,
                        key_low_ff[63:32] ^ FK2, key_low_ff[31:0] ^ FK3};
            cv_in    = {iv_high_ff, iv_low_ff};
            state_in = ST_KEY;
         end else begin
            words_in = src;
            state_in = ST_ROUND;
         end
      end

      // any register write forces re-expansion
      if (cfg_wr && (cfg_idx <= REG_DIR)) begin
         keys_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         keys_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cv_ff         <= '0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         keys_ready_ff <= keys_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
         cv_ff         <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff    <= words_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_high_ff <= rsp_high_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_last_ff <= rsp_last_in;
   end

   // round key store
   sm4cm_rk_ram u_rk_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_KEY),
      .wr_addr (cnt_ff),
      .wr_data (new_word),
      .rd_addr (rd_addr),
      .rd_data (rk_ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_high_ff;
   assign rsp_result_low  = rsp_low_ff;
   assign rsp_last_out    = rsp_last_ff;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the SM4 chaining-mode core: predictor, drivers and checks.
package sm4cm_tb_pkg;
   import sm4cm_pkg::*;

   localparam logic DIR_ENC = 1'b0;
   localparam logic DIR_DEC = 1'b1;

   // Indexes past the register list; writes there must change nothing
   localparam logic [2:0] REG_SPARE_A = 3'd6;
   localparam logic [2:0] REG_SPARE_B = 3'd7;

   localparam logic [7:0] SUBST_BOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
      logic        last;
   } cipher_out_type;

   // Tracks key schedule, chaining value and the blocks still owed by the core
   class sm4_chain_model;
      logic [63:0] key_hi = '0;
      logic [63:0] key_lo = '0;
      logic [63:0] iv_hi  = '0;
      logic [63:0] iv_lo  = '0;
      logic [1:0]  mode   = MODE_ECB;
      logic        dir    = DIR_ENC;
      logic [31:0] rk_store [32];
      logic [127:0] chain_val = '0;
      bit          keys_valid = 1'b0;
      cipher_out_type pending_blocks [$];
      int          mismatch_count = 0;
      int          blocks_checked = 0;

      function logic [31:0] sub_word(logic [31:0] x);
         return {SUBST_BOX[x[31:24]], SUBST_BOX[x[23:16]], SUBST_BOX[x[15:8]], SUBST_BOX[x[7:0]]};
      endfunction

      function logic [31:0] rotl(logic [31:0] x, int n);
         return (x << n) | (x >> (32 - n));
      endfunction

      // Key schedule: FK whitening, then 32 rounds with CK and L'
      function void expand_round_keys();
         logic [31:0] k0, k1, k2, k3, ck, t, nk;
         k0 = key_hi[63:32] ^ 32'ha3b1bac6;
         k1 = key_hi[31:0]  ^ 32'h56aa3350;
         k2 = key_lo[63:32] ^ 32'h677d9197;
         k3 = key_lo[31:0]  ^ 32'hb27022dc;
         for (int i = 0; i < 32; i++) begin
            ck = '0;
            for (int j = 0; j < 4; j++)
               ck = {ck[23:0], 8'(((4 * i + j) * 7) & 255)};
            t  = sub_word(k1 ^ k2 ^ k3 ^ ck);
            nk = k0 ^ t ^ rotl(t, 13) ^ rotl(t, 23);
            rk_store[i] = nk;
            k0 = k1; k1 = k2; k2 = k3; k3 = nk;
         end
      endfunction

      // 32 data rounds; rev walks the key store backwards
      function logic [127:0] run_rounds(logic [127:0] blk, logic rev);
         logic [31:0] x0, x1, x2, x3, t, nx;
         {x0, x1, x2, x3} = blk;
         for (int i = 0; i < 32; i++) begin
            t  = sub_word(x1 ^ x2 ^ x3 ^ rk_store[rev ? 31 - i : i]);
            nx = x0 ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
            x0 = x1; x1 = x2; x2 = x3; x3 = nx;
         end
         return {x3, x2, x1, x0};
      endfunction

      function void write_reg(logic [2:0] idx, logic [63:0] value);
         case (idx)
            REG_KEY_HIGH: key_hi = value;
            REG_KEY_LOW:  key_lo = value;
            REG_IV_HIGH:  iv_hi  = value;
            REG_IV_LOW:   iv_lo  = value;
            REG_MODE:     mode   = value[1:0];
            REG_DIR:      dir    = value[0];
            default:      return;
         endcase
         keys_valid = 1'b0;
      endfunction

      // Accepted request: work out the block the core must return
      function void take_request(logic [63:0] hi, logic [63:0] lo, logic last);
         logic [127:0] din, ks, res;
         cipher_out_type item;
         if (!keys_valid) begin
            expand_round_keys();
            chain_val  = {iv_hi, iv_lo};
            keys_valid = 1'b1;
         end
         din = {hi, lo};
         case (mode)
            MODE_ECB: res = run_rounds(din, dir == DIR_DEC);
            MODE_CBC: begin
               if (dir == DIR_ENC) begin
                  res = run_rounds(din ^ chain_val, 1'b0);
                  chain_val = res;
               end else begin
                  res = run_rounds(din, 1'b1) ^ chain_val;
                  chain_val = din;
               end
            end
            MODE_CFB: begin
               res = run_rounds(chain_val, 1'b0) ^ din;
               chain_val = (dir == DIR_DEC) ? din : res;
            end
            default: begin
               ks = run_rounds(chain_val, 1'b0);
               chain_val = ks;
               res = ks ^ din;
            end
         endcase
         item.high = res[127:64];
         item.low  = res[63:0];
         item.last = last;
         pending_blocks.push_back(item);
      endfunction

      function void note_mismatch(string fld, logic [63:0] want, logic [63:0] got);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: block %0d %s expected %h got %h", blocks_checked, fld, want, got);
      endfunction

      function void check_result(logic [63:0] hi, logic [63:0] lo, logic last);
         cipher_out_type want;
         if (pending_blocks.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: result %h %h last=%b with no request outstanding", hi, lo, last);
            return;
         end
         want = pending_blocks.pop_front();
         blocks_checked++;
         if (hi !== want.high) note_mismatch("result_high", want.high, hi);
         if (lo !== want.low)  note_mismatch("result_low", want.low, lo);
         if (last !== want.last) note_mismatch("last_out", 64'(want.last), 64'(last));
      endfunction
   endclass
endpackage

module tb_top;
   import sm4cm_pkg::*;
   import sm4cm_tb_pkg::*;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid, req_stall, req_last_block;
   logic [HALF_W-1:0] req_data_high, req_data_low;
   logic              rsp_valid, rsp_stall, rsp_last_out;
   logic [HALF_W-1:0] rsp_result_high, rsp_result_low;
   logic              csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata, csr_prdata;

   sm4_chain_model chain;
   bit  steady;             // both sides run without gaps
   int  hold_off_len = 0;   // one-shot long stall request for the result side
   int  requests_sent = 0;
   int  phase_count = 0;
   int  reg_writes = 0;

   sm4_cipher_with_chaining_modes_core u_top (.*);

   always #1 clock = ~clock;

   // Watchdog
   initial begin
      #2000000;
      $display("ERROR: timeout with %0d blocks outstanding", chain.pending_blocks.size());
      $display("CHECK FAILED");
      $finish;
   end

   // Sample both handshakes with the values present before the edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         chain.take_request(req_data_high, req_data_low, req_last_block);
      if (!reset && rsp_valid && !rsp_stall)
         chain.check_result(rsp_result_high, rsp_result_low, rsp_last_out);
   end

   function automatic int pick_wait();
      return steady ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Result side: random stall per block, plus the one long hold-off
   initial begin
      int gap;
      rsp_stall <= 1'b0;
      forever begin
         if (hold_off_len > 0) begin
            gap = hold_off_len;
            hold_off_len = 0;
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         gap = pick_wait();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Register write: setup phase, access phase, then the bus is left idle
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      chain.write_reg(idx, value);
      reg_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one block; valid stays high into the next request when no gap follows
   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic last);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_high  <= hi;
      req_data_low   <= lo;
      req_last_block <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // Drop valid and let the core drain so registers may be touched
   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chain.pending_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      phase_count++;
   endtask

   initial begin
      logic [1:0] chain_modes [3];
      int         phase_len;
      chain_modes = '{MODE_CBC, MODE_CFB, MODE_OFB};
      chain = new();
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_high  <= '0;
      req_data_low   <= '0;
      req_last_block <= 1'b0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      steady         = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset: zero key, ECB encrypt, field extremes
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b1);
      finish_phase();

      // Standard test vector, then decrypt its ciphertext
      csr_write(REG_KEY_HIGH, 64'h0123456789abcdef);
      csr_write(REG_KEY_LOW, 64'hfedcba9876543210);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
      finish_phase();
      csr_write(REG_DIR, 64'(DIR_DEC));
      send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b0);
      finish_phase();

      // Every feedback mode in both directions, IV all ones or zero high half with a random low half
      for (int m = 0; m < 3; m++) begin
         for (int d = 0; d < 2; d++) begin
            csr_write(REG_IV_HIGH, ((m + d) % 2) ? '1 : '0);
            csr_write(REG_IV_LOW, ((m + d) % 2) ? '1 : pick_word());
            csr_write(REG_MODE, 64'(chain_modes[m]));
            csr_write(REG_DIR, (d == 0) ? 64'(DIR_ENC) : 64'(DIR_DEC));
            send_block('0, '0, 1'b0);
            send_block(pick_word(), '1, 1'b1);
            finish_phase();
         end
      end

      // Writes past the register list must not restart the chain
      csr_write(REG_SPARE_A, '1);
      csr_write(REG_SPARE_B, '1);
      send_block(pick_word(), pick_word(), 1'b0);
      send_block(pick_word(), pick_word(), 1'b1);
      finish_phase();

      // Mode and direction with junk in unused bits; ECB with a nonzero IV
      csr_write(REG_MODE, {62'h3fff_ffff_ffff_ffff, MODE_ECB});
      csr_write(REG_DIR, {63'h7fff_ffff_ffff_ffff, DIR_DEC});
      send_block(pick_word(), pick_word(), 1'b1);
      finish_phase();

      // Random phases: new settings, then a burst of blocks
      while (requests_sent < 1700) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) csr_write(REG_KEY_HIGH, pick_word());
         if ($urandom_range(0, 2) == 0) csr_write(REG_KEY_LOW, pick_word());
         if ($urandom_range(0, 2) == 0) csr_write(REG_IV_HIGH, pick_word());
         if ($urandom_range(0, 2) == 0) csr_write(REG_IV_LOW, pick_word());
         if ($urandom_range(0, 1) == 0) csr_write(REG_MODE, 64'($urandom_range(0, 3)));
         if ($urandom_range(0, 1) == 0) csr_write(REG_DIR, 64'($urandom_range(0, 1)));
         if ($urandom_range(0, 9) == 0)
            csr_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, pick_word());
         phase_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         // Once: starve the result side so the core backs up into the request side
         if (phase_count == 20) begin
            hold_off_len = 400;
            steady = 1'b1;
            phase_len = 16;
         end
         for (int i = 0; i < phase_len; i++)
            send_block(pick_word(), pick_word(), 1'($urandom_range(0, 1)));
         finish_phase();
      end

      steady = 1'b0;
      repeat (70) @(posedge clock);
      $display("Sent %0d blocks over %0d phases with %0d register writes, all modes both ways.",
               requests_sent, phase_count, reg_writes);
      $display("Compared %0d results, %0d field mismatches, %0d left outstanding.",
               chain.blocks_checked, chain.mismatch_count, chain.pending_blocks.size());
      if (chain.mismatch_count == 0 && chain.pending_blocks.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
